// ----- rtl/kdef_pkg.sv -----
// Shared types and constants for the keypad debounce event FIFO.
package kdef_pkg;

  localparam int NUM_KEYS    = 16;
  localparam int FIFO_DEPTH  = 32;
  localparam int KEY_W       = $clog2(NUM_KEYS);
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
  localparam int EVT_W       = KEY_W + 1;
  localparam int RAW_W       = 16;
  localparam int TIME_W      = 32;
  localparam int DBMS_W      = 16;
  localparam int QLEVEL_W    = 6;
  localparam int EVT_KEY_W   = 4;

  localparam logic [DBMS_W-1:0] DEBOUNCE_RESET = DBMS_W'(20);

  // Request kinds
  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [RAW_W-1:0]  raw_keys;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                 event_valid;
    logic [EVT_KEY_W-1:0] event_key;
    logic                 event_pressed;
    logic [QLEVEL_W-1:0]  queue_level;
    logic                 scan_dropped;
  } out_item_t;

  // Decoded request handed from front to back
  typedef struct packed {
    logic              is_pop;
    logic [RAW_W-1:0]  raw;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_SCAN
  } back_state_t;

endpackage

// ----- rtl/kdef_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kdef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/kdef_front.sv -----
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
module kdef_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  kdef_pkg::in_item_t in_item,
  output logic              cmd_valid,
  output kdef_pkg::cmd_t    cmd,
  input  logic              cmd_take
);
  import kdef_pkg::*;

  cmd_t        q_r [2];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push_ok;
  logic        take_ok;
  cmd_t        dec;

  // Decode the incoming request
  always_comb begin
    dec.is_pop = (in_item.kind == KIND_POP);
    dec.raw    = in_item.raw_keys;
    dec.now    = in_item.now_ms;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push_ok   = in_push && !in_full;
  assign take_ok   = cmd_take && cmd_valid;

  // Pointer and count update
  always_comb begin
    wp_nxt  = push_ok ? ~wp_r : wp_r;
    rp_nxt  = take_ok ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push_ok && !take_ok) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push_ok && take_ok) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

// ----- rtl/kdef_back.sv -----
// Back end: per-key debounce sequencer, event ring FIFO control and result register.
module kdef_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  kdef_pkg::cmd_t                cmd,
  output logic                          cmd_take,
  input  logic                          cfg_we,
  input  logic [kdef_pkg::DBMS_W-1:0]   cfg_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output kdef_pkg::out_item_t           out_item
);
  import kdef_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  back_state_t        state_r, state_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [RAW_W-1:0]   raw_r, raw_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic               drop_r, drop_nxt;
  logic [NUM_KEYS-1:0] deb_r, deb_nxt;
  logic [TIME_W-1:0]  lct_r [NUM_KEYS];
  logic               lct_we;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [DBMS_W-1:0]  dbms_r;
  out_item_t          res_r, res_nxt;
  logic               res_vld_r, res_vld_nxt;

  logic               lvl;
  logic [TIME_W-1:0]  elapsed;
  logic               chg;
  logic [SUM_W-1:0]   tail_sum;
  logic [SUM_W-1:0]   tail;
  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [EVT_W-1:0]   ram_wdata;
  logic [EVT_W-1:0]   ram_rdata;
  logic               fifo_full;

  // Event store
  kdef_ram #(
    .WIDTH (EVT_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Current key evaluation: level change allowed after the debounce time
  assign lvl       = raw_r[key_r];
  assign elapsed   = now_r - lct_r[key_r];
  assign chg       = (lvl != deb_r[key_r]) && (elapsed >= TIME_W'(dbms_r));
  assign fifo_full = (count_r == CNT_W'(FIFO_DEPTH));

  // Tail slot = (head + count) mod depth, sum stays below twice the depth
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail      = (tail_sum >= SUM_W'(FIFO_DEPTH)) ?
                     (tail_sum - SUM_W'(FIFO_DEPTH)) : tail_sum;
  assign ram_waddr = tail[PTR_W-1:0];
  assign ram_wdata = {key_r, lvl};

  assign out_empty = !res_vld_r;
  assign out_item  = res_r;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    key_nxt     = key_r;
    raw_nxt     = raw_r;
    now_nxt     = now_r;
    drop_nxt    = drop_r;
    deb_nxt     = deb_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r && !out_pop;
    cmd_take    = 1'b0;
    ram_we      = 1'b0;
    lct_we      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && !res_vld_r) begin
          cmd_take = 1'b1;
          if (cmd.is_pop) begin
            if (count_r == '0) begin
              res_nxt     = '0;
              res_vld_nxt = 1'b1;
            end else begin
              state_nxt = ST_POP_RD;
            end
          end else begin
            raw_nxt   = cmd.raw;
            now_nxt   = cmd.now;
            key_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_POP_RD: begin
        // Read data for the head slot is now valid
        res_nxt.event_valid   = 1'b1;
        res_nxt.event_key     = EVT_KEY_W'(ram_rdata[EVT_W-1:1]);
        res_nxt.event_pressed = ram_rdata[0];
        res_nxt.queue_level   = QLEVEL_W'(count_r - CNT_W'(1));
        res_nxt.scan_dropped  = 1'b0;
        res_vld_nxt           = 1'b1;
        count_nxt             = count_r - CNT_W'(1);
        head_nxt              = (head_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                                head_r + PTR_W'(1);
        state_nxt             = ST_IDLE;
      end
      ST_SCAN: begin
        if (chg) begin
          deb_nxt[key_r] = lvl;
          lct_we         = 1'b1;
          if (fifo_full) begin
            drop_nxt = 1'b1;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        key_nxt = key_r + KEY_W'(1);
        if (key_r == KEY_W'(NUM_KEYS - 1)) begin
          res_nxt              = '0;
          res_nxt.queue_level  = QLEVEL_W'(count_nxt);
          res_nxt.scan_dropped = drop_nxt;
          res_vld_nxt          = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      key_r     <= '0;
      drop_r    <= 1'b0;
      deb_r     <= '0;
      head_r    <= '0;
      count_r   <= '0;
      res_vld_r <= 1'b0;
      dbms_r    <= DEBOUNCE_RESET;
    end else begin
      state_r   <= state_nxt;
      key_r     <= key_nxt;
      drop_r    <= drop_nxt;
      deb_r     <= deb_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      res_vld_r <= res_vld_nxt;
      if (cfg_we) begin
        dbms_r <= cfg_data;
      end
    end
  end

  // Last-change times, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        lct_r[i] <= '0;
      end
    end else if (lct_we) begin
      lct_r[key_r] <= now_r;
    end
  end

  // Scan payload and result register
  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
    now_r <= now_nxt;
    res_r <= res_nxt;
  end

endmodule

// ----- rtl/keypad_debounce_event_fifo.sv -----
// Top level of the keypad debounce event FIFO.
// Usage:
//   Requests enter through a queue port: drive in_item and raise in_push; the
//   request is taken on a clock edge where in_full is low. A request is either
//   a scan snapshot (16 raw key levels plus a millisecond timestamp) or a pop.
//   Results leave through a queue port: while out_empty is low the oldest
//   result sits on out_item; raise out_pop to take it. Exactly one result is
//   produced per request, in request order.
//   cfg_debounce_ms is written when cfg_valid is high (cfg_ready is always
//   high); write it only while the block is idle.
// Timing:
//   A scan leaves the request queue, then walks the keys one per cycle
//   through the shared debounce compare; its result is ready after the last
//   key. A pop reads the event store with a registered read, so its result
//   is ready after the ST_POP_RD state.
//   The back end takes the next request in the cycle after the result is
//   popped: it does not start a new request while a result waits.
//   A two-entry request queue keeps accepting while a result waits; when the
//   receiver stalls, the result holds and the block stops after two more
//   requests, with in_full high.
// Reset (synchronous, rst_n low): all keys released, last-change times zero,
//   event FIFO empty, debounce time 20 ms. No clearing pass is needed.
module keypad_debounce_event_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  kdef_pkg::in_item_t               in_item,
  output logic                             out_empty,
  input  logic                             out_pop,
  output kdef_pkg::out_item_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kdef_pkg::DBMS_W-1:0]      cfg_debounce_ms
);
  import kdef_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  assign cfg_ready = 1'b1;

  // Request decode and queue
  kdef_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // Debounce sequencer and event FIFO
  kdef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_debounce_ms),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
